>>> src/lss_pkg.sv
// Shared types and constants for the LIFO stack with search.
`default_nettype none
package lss_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int POS_W = 6;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_PUSHED   = 3'd0,
		ST_POPPED   = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_FOUND    = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic push_acc;
		logic pop_acc;
		logic search_acc;
		logic pop_out;
		logic walk;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic at_bottom;
	} sts_t;

endpackage
`default_nettype wire

>>> src/lss_ctrl.sv
// Controller state machine: accepts commands and sequences pop and search.
`default_nettype none
module lss_ctrl
	import lss_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] opcode,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic            busy
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_WALK = 5'b00100,
		S_LAST = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.push_acc   = accept && (opcode == OP_PUSH);
		cmd.pop_acc    = accept && (opcode == OP_POP);
		cmd.search_acc = accept && (opcode == OP_SEARCH);
		cmd.pop_out    = (state_q == S_POP);
		cmd.walk       = (state_q == S_WALK);
		cmd.fin        = (state_q == S_FIN);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.pop_acc && !sts.empty)
					state_d = S_POP;
				else if (cmd.search_acc && !sts.empty)
					state_d = S_WALK;
			end
			S_POP:  state_d = S_IDLE;
			S_WALK: begin
				if (sts.at_bottom)
					state_d = S_LAST;
			end
			// last entry still in the compare stage
			S_LAST: state_d = S_FIN;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

>>> src/lss_dp.sv
// Datapath: entry memory, fill count, search walk and result register.
`default_nettype none
module lss_dp
	import lss_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	input  wire logic signed [DW-1:0]    value,
	output sts_t                         sts,
	output logic                         strobe,
	output logic [2:0]                   status,
	output logic signed [DW-1:0]         data,
	output logic [POS_W-1:0]             position,
	output logic                         last
);

	logic [DW-1:0]    mem [DEPTH];
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    top;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    pos_q;
	logic [DW-1:0]    key_q;
	logic [DW-1:0]    rd_s1;
	logic [AW-1:0]    pos_s1;
	logic             vld_s1;
	logic             pend_q;
	logic [AW-1:0]    pend_pos_q;
	logic             match;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	logic             emit;
	status_t          e_status;
	logic [DW-1:0]    e_data;
	logic [POS_W-1:0] e_pos;
	logic             e_last;

	logic             strobe_q;
	logic [2:0]       status_q;
	logic [DW-1:0]    data_q;
	logic [POS_W-1:0] position_q;
	logic             last_q;

	assign sts.empty     = (fill_q == '0);
	assign sts.full      = (fill_q == CW'(DEPTH));
	assign sts.at_bottom = (ptr_q == '0);

	assign top     = AW'(fill_q - CW'(1));
	assign rd_en   = (cmd.pop_acc && !sts.empty) || cmd.walk;
	assign rd_addr = cmd.pop_acc ? top : ptr_q;
	assign match   = vld_s1 && (rd_s1 == key_q);

	always_ff @(posedge clk) begin
		if (cmd.push_acc && !sts.full)
			mem[fill_q[AW-1:0]] <= value;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_s1 <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.push_acc && !sts.full)
				fill_q <= fill_q + CW'(1);
			else if (cmd.pop_acc && !sts.empty)
				fill_q <= fill_q - CW'(1);
			vld_s1 <= cmd.walk;
			if (cmd.search_acc)
				pend_q <= 1'b0;
			else if (match)
				pend_q <= 1'b1;
		end
	end

	// walk runs from the top entry down; a match is held back until the next
	// match or the end of the walk so that the final one can be flagged
	always_ff @(posedge clk) begin
		if (cmd.search_acc) begin
			key_q <= value;
			ptr_q <= top;
			pos_q <= '0;
		end else if (cmd.walk) begin
			ptr_q <= ptr_q - AW'(1);
			pos_q <= pos_q + AW'(1);
		end
		if (cmd.walk)
			pos_s1 <= pos_q;
		if (match)
			pend_pos_q <= pos_s1;
	end

	always_comb begin
		emit     = 1'b0;
		e_status = ST_PUSHED;
		e_data   = value;
		e_pos    = '0;
		e_last   = 1'b1;
		priority if (cmd.push_acc) begin
			emit     = 1'b1;
			e_status = sts.full ? ST_OVERFLOW : ST_PUSHED;
		end else if (cmd.pop_acc && sts.empty) begin
			emit     = 1'b1;
			e_status = ST_EMPTY;
			e_data   = '0;
		end else if (cmd.search_acc && sts.empty) begin
			emit     = 1'b1;
			e_status = ST_EMPTY;
		end else if (cmd.pop_out) begin
			emit     = 1'b1;
			e_status = ST_POPPED;
			e_data   = rd_s1;
		end else if (match && pend_q) begin
			emit     = 1'b1;
			e_status = ST_FOUND;
			e_data   = key_q;
			e_pos    = POS_W'(pend_pos_q);
			e_last   = 1'b0;
		end else if (cmd.fin) begin
			emit     = 1'b1;
			e_status = pend_q ? ST_FOUND : ST_NOTFOUND;
			e_data   = key_q;
			e_pos    = pend_q ? POS_W'(pend_pos_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= e_status;
			data_q     <= e_data;
			position_q <= e_pos;
			last_q     <= e_last;
		end
	end

	assign strobe   = strobe_q;
	assign status   = status_q;
	assign data     = data_q;
	assign position = position_q;
	assign last     = last_q;

endmodule
`default_nettype wire

>>> src/lifo_stack_with_search_unit.sv
// Top level of the LIFO stack with search.
//
// A command is taken when start is high and busy is low. Each result beat
// is shown for one cycle with strobe high, the cycle after it is formed; the
// receiver cannot stall, so it must take every beat as it comes. Push (and
// any rejected command) produces its beat in the cycle after acceptance and
// leaves busy low, so commands may follow back to back. Pop holds busy
// through the S_POP state, which covers the registered read of the entry memory.
// Search walks the held entries from the top, one memory read per cycle,
// and holds busy through the walk and the S_LAST and S_FIN states; each
// match beat is held back until the next match or the end of the walk, so
// that the last one can be flagged. Opcode 3 is taken and ignored.
`default_nettype none
module lifo_stack_with_search_unit
	import lss_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          opcode,
	input  wire logic signed [31:0]  value,
	output logic                     busy,
	output logic                     strobe,
	output logic [2:0]               status,
	output logic signed [31:0]       data,
	output logic [5:0]               position,
	output logic                     last
);

	cmd_t cmd;
	sts_t sts;

	lss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	lss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (value),
		.sts      (sts),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.position (position),
		.last     (last)
	);

endmodule
`default_nettype wire
